// ----- rtl/dfir_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimating FIR filter package
// Shared sizes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dfir_pkg;

   localparam int MAX_TAPS    = 64;
   localparam int TAP_AW      = $clog2(MAX_TAPS);
   localparam int MAX_DECIM   = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int OUT_BITS    = 38;
   localparam int CFG_BITS    = 7;
   localparam int CSR_AW      = 2;
   localparam int REQ_BITS    = 56;
   localparam int RSP_BITS    = 80;

   localparam logic [CSR_AW-1:0] CSR_DECIMATION   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TAP_COUNT    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_COMPLEX_MODE = 2'd2;

   localparam logic CMD_SAMPLE    = 1'b0;
   localparam logic CMD_TAP_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic smp_wr;
      logic tap_wr;
      logic acc_clr;
      logic issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic last_issue;
      logic pipe_idle;
      logic out_full;
   } status_type;

endpackage

// ----- rtl/decimating_fir_filter.sv -----
// ----------------------------------------------------------------------------
// Decimating FIR filter
// Real-tap FIR over real or complex Q1.15 samples with output decimation.
// ----------------------------------------------------------------------------
// A tap-write request or a sample that produces no output is taken in the
// idle state. A sample that produces an output starts a tap walk: the taps are
// walked one per cycle through one 16x16 multiplier per part, read from
// single-port delay and tap memories, followed by a three-deep drain of the
// read/multiply/accumulate pipe and the result load. A finished result waits
// in the output register while the next request is taken.
module decimating_fir_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dfir_pkg::CSR_AW-1:0]           csr_addr,
   input  logic [dfir_pkg::CFG_BITS-1:0]         csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sample_re[15:0], sample_im[31:16], tap_index[37:32], tap_value[53:38]
   input  logic [dfir_pkg::REQ_BITS-1:0]         req_tdata,
   // cmd
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_re[37:0], out_im[75:38]
   output logic [dfir_pkg::RSP_BITS-1:0]         rsp_tdata
);

   localparam int SB = dfir_pkg::SAMPLE_BITS;
   localparam int AW = dfir_pkg::TAP_AW;
   localparam int OB = dfir_pkg::OUT_BITS;

   dfir_pkg::cmd_type    cmd;
   dfir_pkg::status_type status;
   logic signed [OB-1:0] out_re, out_im;

   dfir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   dfir_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .sample_re  (req_tdata[SB-1:0]),
      .sample_im  (req_tdata[2*SB-1:SB]),
      .tap_index  (req_tdata[2*SB+AW-1:2*SB]),
      .tap_value  (req_tdata[3*SB+AW-1:2*SB+AW]),
      .cmd        (cmd),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .out_re     (out_re),
      .out_im     (out_im)
   );

   assign rsp_tdata = {(dfir_pkg::RSP_BITS - 2*OB)'(0), out_im, out_re};

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result loaded over a pending result");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result valid without a load");

   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.tap_wr || cmd.smp_wr) |-> (req_tvalid && req_tready))
      else $error("memory write without an accepted request");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.tap_wr, cmd.smp_wr, cmd.issue, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

// ----- rtl/dfir_ctrl.sv -----
// ----------------------------------------------------------------------------
// Decimating FIR filter controller
// Sequences request intake, the tap walk, pipeline drain and result load.
// ----------------------------------------------------------------------------
module dfir_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_cmd,
   input  dfir_pkg::status_type status,
   output logic                req_tready,
   output dfir_pkg::cmd_type    cmd
);

   dfir_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfir_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         dfir_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd == dfir_pkg::CMD_TAP_WRITE) begin
                  cmd.tap_wr = 1'b1;
               end else begin
                  cmd.smp_wr = 1'b1;
                  if (status.emit) begin
                     cmd.acc_clr = 1'b1;
                     state_in    = dfir_pkg::ST_RUN;
                  end
               end
            end
         end
         dfir_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = dfir_pkg::ST_DRAIN;
            end
         end
         dfir_pkg::ST_DRAIN: begin
            if (status.pipe_idle) begin
               state_in = dfir_pkg::ST_OUT;
            end
         end
         dfir_pkg::ST_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = dfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dfir_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/dfir_dp.sv -----
// ----------------------------------------------------------------------------
// Decimating FIR filter datapath
// Settings, delay and tap memories, decimation phase, MAC pipe, result reg.
// ----------------------------------------------------------------------------
module dfir_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dfir_pkg::CSR_AW-1:0]           csr_addr,
   input  logic [dfir_pkg::CFG_BITS-1:0]         csr_wdata,
   input  logic signed [dfir_pkg::SAMPLE_BITS-1:0] sample_re,
   input  logic signed [dfir_pkg::SAMPLE_BITS-1:0] sample_im,
   input  logic [dfir_pkg::TAP_AW-1:0]           tap_index,
   input  logic signed [dfir_pkg::SAMPLE_BITS-1:0] tap_value,
   input  dfir_pkg::cmd_type                      cmd,
   input  logic                                  rsp_tready,
   output dfir_pkg::status_type                   status,
   output logic                                  rsp_tvalid,
   output logic signed [dfir_pkg::OUT_BITS-1:0]  out_re,
   output logic signed [dfir_pkg::OUT_BITS-1:0]  out_im
);

   localparam int SB = dfir_pkg::SAMPLE_BITS;
   localparam int AW = dfir_pkg::TAP_AW;
   localparam int CW = dfir_pkg::CFG_BITS;
   localparam int PB = dfir_pkg::PROD_BITS;
   localparam int OB = dfir_pkg::OUT_BITS;

   logic [CW-1:0] decimation_ff, tap_count_ff;
   logic          complex_mode_ff;

   logic signed [SB-1:0] delay_re_mem [dfir_pkg::MAX_TAPS];
   logic signed [SB-1:0] delay_im_mem [dfir_pkg::MAX_TAPS];
   logic signed [SB-1:0] tap_mem      [dfir_pkg::MAX_TAPS];
   logic [dfir_pkg::MAX_TAPS-1:0] tap_vld_ff;

   logic [AW-1:0] wp_ff, j_ff, rd_addr, ntaps_m1;
   logic [CW-1:0] fill_ff, dec, ph1;
   logic [AW-1:0] phase_ff, ph0, phase_in;

   logic signed [SB-1:0] rd_re_ff, rd_im_ff, rd_tap_ff;
   logic                 s1_vld_ff, s1_keep_ff, s2_vld_ff;
   logic signed [PB-1:0] prod_re_ff, prod_im_ff;
   logic signed [OB-1:0] acc_re_ff, acc_im_ff;
   logic                 rsp_valid_ff;
   logic signed [OB-1:0] rsp_re_ff, rsp_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff   <= CW'(1);
         tap_count_ff    <= CW'(1);
         complex_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            dfir_pkg::CSR_DECIMATION:   decimation_ff   <= csr_wdata;
            dfir_pkg::CSR_TAP_COUNT:    tap_count_ff    <= csr_wdata;
            dfir_pkg::CSR_COMPLEX_MODE: complex_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (decimation_ff == '0) begin
         dec = CW'(1);
      end else if (decimation_ff > CW'(dfir_pkg::MAX_DECIM)) begin
         dec = CW'(dfir_pkg::MAX_DECIM);
      end else begin
         dec = decimation_ff;
      end
      if (tap_count_ff == '0) begin
         ntaps_m1 = '0;
      end else if (tap_count_ff > CW'(dfir_pkg::MAX_TAPS)) begin
         ntaps_m1 = AW'(dfir_pkg::MAX_TAPS - 1);
      end else begin
         ntaps_m1 = AW'(tap_count_ff - CW'(1));
      end
      ph0      = ({1'b0, phase_ff} >= dec) ? '0 : phase_ff;
      ph1      = {1'b0, ph0} + CW'(1);
      phase_in = (ph1 >= dec) ? '0 : ph1[AW-1:0];
      rd_addr  = wp_ff - AW'(1) - j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         fill_ff    <= '0;
         phase_ff   <= '0;
         tap_vld_ff <= '0;
         j_ff       <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
      end else begin
         if (cmd.smp_wr) begin
            wp_ff    <= wp_ff + AW'(1);
            phase_ff <= phase_in;
            if (fill_ff != CW'(dfir_pkg::MAX_TAPS)) begin
               fill_ff <= fill_ff + CW'(1);
            end
         end
         if (cmd.tap_wr) begin
            tap_vld_ff[tap_index] <= 1'b1;
         end
         if (cmd.acc_clr) begin
            j_ff <= '0;
         end else if (cmd.issue) begin
            j_ff <= j_ff + AW'(1);
         end
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.smp_wr) begin
         delay_re_mem[wp_ff] <= sample_re;
         delay_im_mem[wp_ff] <= complex_mode_ff ? sample_im : '0;
      end
      if (cmd.tap_wr) begin
         tap_mem[tap_index] <= tap_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_re_ff   <= delay_re_mem[rd_addr];
         rd_im_ff   <= delay_im_mem[rd_addr];
         rd_tap_ff  <= tap_mem[j_ff];
         s1_keep_ff <= ({1'b0, j_ff} < fill_ff) && tap_vld_ff[j_ff];
      end
      if (s1_vld_ff) begin
         prod_re_ff <= s1_keep_ff ? rd_tap_ff * rd_re_ff : PB'(0);
         prod_im_ff <= s1_keep_ff ? rd_tap_ff * rd_im_ff : PB'(0);
      end
      if (cmd.acc_clr) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_re_ff <= acc_re_ff + OB'(prod_re_ff);
         acc_im_ff <= acc_im_ff + OB'(prod_im_ff);
      end
      if (cmd.out_load) begin
         rsp_re_ff <= acc_re_ff;
         rsp_im_ff <= complex_mode_ff ? acc_im_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.emit       = (ph0 == '0);
   assign status.last_issue = (j_ff == ntaps_m1);
   assign status.pipe_idle  = !s1_vld_ff && !s2_vld_ff;
   assign status.out_full   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign out_re     = rsp_re_ff;
   assign out_im     = rsp_im_ff;

endmodule

// ----- tb/tb_decimating_fir_filter.sv -----
// ----------------------------------------------------------------------------
// Decimating FIR filter testbench
// Loads taps, streams real and complex samples and changes the register
// settings between bursts; every filter output is predicted and checked.
// ----------------------------------------------------------------------------
module tb_decimating_fir_filter;

   localparam int SETTLE_CYCLES = dfir_pkg::MAX_TAPS + 16;
   localparam int ITEM_TARGET   = 500;
   localparam int OUTPUT_TARGET = 48;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      logic                                    cmd;
      logic signed [dfir_pkg::SAMPLE_BITS-1:0] re;
      logic signed [dfir_pkg::SAMPLE_BITS-1:0] im;
      logic [dfir_pkg::TAP_AW-1:0]             tap_index;
      logic signed [dfir_pkg::SAMPLE_BITS-1:0] tap_value;
   } request_type;

   typedef struct {
      logic signed [dfir_pkg::OUT_BITS-1:0] re;
      logic signed [dfir_pkg::OUT_BITS-1:0] im;
   } output_type;

   typedef struct {
      row_kind_type                  kind;
      request_type                   request;
      logic [dfir_pkg::CSR_AW-1:0]   addr;
      logic [dfir_pkg::CFG_BITS-1:0] value;
      bit                            typed;
      output_type                    result;
   } row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [dfir_pkg::CSR_AW-1:0]   csr_addr;
   logic [dfir_pkg::CFG_BITS-1:0] csr_wdata;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [dfir_pkg::REQ_BITS-1:0] req_tdata;
   logic                          req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [dfir_pkg::RSP_BITS-1:0] rsp_tdata;

   logic signed [dfir_pkg::SAMPLE_BITS-1:0] line_re [dfir_pkg::MAX_TAPS];
   logic signed [dfir_pkg::SAMPLE_BITS-1:0] line_im [dfir_pkg::MAX_TAPS];
   logic signed [dfir_pkg::SAMPLE_BITS-1:0] coef [dfir_pkg::MAX_TAPS];
   int unsigned                             phase_pos;
   logic [dfir_pkg::CFG_BITS-1:0]           decim_reg;
   logic [dfir_pkg::CFG_BITS-1:0]           ntaps_reg;
   logic                                    cplx_reg;

   output_type pending_outputs [$];
   row_type    plan [$];
   int         requests_sent;
   int         tap_writes;
   int         outputs_predicted;
   int         outputs_checked;
   int         mismatches;
   int         settings_used;
   bit         req_quiet;
   bit         rsp_quiet;

   decimating_fir_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic bit filter_step(input request_type r, output output_type y);
      int unsigned        dec;
      int unsigned        taps;
      logic signed [63:0] acc_re;
      logic signed [63:0] acc_im;
      logic signed [63:0] prod;
      bit                 emit;
      y.re = '0;
      y.im = '0;
      if (r.cmd == dfir_pkg::CMD_TAP_WRITE) begin
         coef[r.tap_index] = r.tap_value;
         return 1'b0;
      end
      dec  = (decim_reg == 0) ? 1 :
             (decim_reg > dfir_pkg::MAX_DECIM) ? dfir_pkg::MAX_DECIM : decim_reg;
      taps = (ntaps_reg == 0) ? 1 :
             (ntaps_reg > dfir_pkg::MAX_TAPS) ? dfir_pkg::MAX_TAPS : ntaps_reg;
      for (int j = dfir_pkg::MAX_TAPS - 1; j > 0; j--) begin
         line_re[j] = line_re[j-1];
         line_im[j] = line_im[j-1];
      end
      line_re[0] = r.re;
      line_im[0] = cplx_reg ? r.im : '0;
      if (phase_pos >= dec) phase_pos = 0;
      emit = (phase_pos == 0);
      phase_pos++;
      if (phase_pos >= dec) phase_pos = 0;
      if (!emit) return 1'b0;
      acc_re = '0;
      acc_im = '0;
      for (int j = 0; j < taps; j++) begin
         prod   = coef[j] * line_re[j];
         acc_re = acc_re + prod;
         prod   = coef[j] * line_im[j];
         acc_im = acc_im + prod;
      end
      y.re = acc_re[dfir_pkg::OUT_BITS-1:0];
      y.im = cplx_reg ? acc_im[dfir_pkg::OUT_BITS-1:0] : '0;
      return 1'b1;
   endfunction

   function automatic void add_request(logic cmd, int re, int im, int tap_index, int tap_value,
                                       bit typed = 1'b0, longint exp_re = 0, longint exp_im = 0);
      row_type row;
      row.kind              = ROW_REQUEST;
      row.request.cmd       = cmd;
      row.request.re        = re[dfir_pkg::SAMPLE_BITS-1:0];
      row.request.im        = im[dfir_pkg::SAMPLE_BITS-1:0];
      row.request.tap_index = tap_index[dfir_pkg::TAP_AW-1:0];
      row.request.tap_value = tap_value[dfir_pkg::SAMPLE_BITS-1:0];
      row.addr              = '0;
      row.value             = '0;
      row.typed             = typed;
      row.result.re         = exp_re[dfir_pkg::OUT_BITS-1:0];
      row.result.im         = exp_im[dfir_pkg::OUT_BITS-1:0];
      plan.push_back(row);
   endfunction

   function automatic void add_csr(logic [dfir_pkg::CSR_AW-1:0] addr, int value);
      row_type row;
      row.kind    = ROW_CSR;
      row.request = '{cmd: dfir_pkg::CMD_SAMPLE, re: '0, im: '0,
                      tap_index: '0, tap_value: '0};
      row.addr    = addr;
      row.value   = value[dfir_pkg::CFG_BITS-1:0];
      row.typed   = 1'b0;
      row.result  = '{re: '0, im: '0};
      plan.push_back(row);
   endfunction

   function automatic logic signed [dfir_pkg::SAMPLE_BITS-1:0] random_word();
      logic [31:0] draw;
      draw = $urandom;
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return draw[dfir_pkg::SAMPLE_BITS-1:0];
      endcase
   endfunction

   function automatic request_type random_request(logic cmd, int tap_index);
      request_type r;
      logic [31:0] pick;
      pick        = (tap_index < 0) ? $urandom : tap_index;
      r.cmd       = cmd;
      r.re        = random_word();
      r.im        = random_word();
      r.tap_index = pick[dfir_pkg::TAP_AW-1:0];
      r.tap_value = random_word();
      return r;
   endfunction

   function automatic row_type as_row(request_type r);
      row_type row;
      row.kind    = ROW_REQUEST;
      row.request = r;
      row.addr    = '0;
      row.value   = '0;
      row.typed   = 1'b0;
      row.result  = '{re: '0, im: '0};
      return row;
   endfunction

   task automatic write_csr(input logic [dfir_pkg::CSR_AW-1:0] addr,
                            input logic [dfir_pkg::CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         dfir_pkg::CSR_DECIMATION:   decim_reg = value;
         dfir_pkg::CSR_TAP_COUNT:    ntaps_reg = value;
         dfir_pkg::CSR_COMPLEX_MODE: cplx_reg  = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_request(input row_type row);
      int         gap;
      output_type y;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.request.cmd;
      req_tdata  <= {{(dfir_pkg::REQ_BITS - 54){1'b0}}, row.request.tap_value,
                     row.request.tap_index, row.request.im, row.request.re};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (row.request.cmd == dfir_pkg::CMD_TAP_WRITE) tap_writes++;
      if (filter_step(row.request, y)) begin
         outputs_predicted++;
         pending_outputs.push_back(row.typed ? row.result : y);
      end
      @(negedge clock);
   endtask

   task automatic run_phase(input int phase_no);
      int dec;
      int taps;
      int cplx;
      int loaded;
      int n;
      settle();
      case (phase_no % 6)
         0: begin
            dec  = dfir_pkg::MAX_DECIM;
            taps = dfir_pkg::MAX_TAPS;
         end
         1: begin
            dec  = 1;
            taps = dfir_pkg::MAX_TAPS;
         end
         2: begin
            dec  = $urandom_range(0, 1) ? 0 : $urandom_range(dfir_pkg::MAX_DECIM + 1, 127);
            taps = $urandom_range(0, 1) ? 0 : $urandom_range(dfir_pkg::MAX_TAPS + 1, 127);
         end
         3: begin
            dec  = $urandom_range(1, dfir_pkg::MAX_DECIM);
            taps = 1;
         end
         default: begin
            dec  = $urandom_range(1, 8);
            taps = $urandom_range(1, 16);
         end
      endcase
      cplx = $urandom_range(0, 1);
      write_csr(dfir_pkg::CSR_DECIMATION, dec[dfir_pkg::CFG_BITS-1:0]);
      write_csr(dfir_pkg::CSR_TAP_COUNT, taps[dfir_pkg::CFG_BITS-1:0]);
      write_csr(dfir_pkg::CSR_COMPLEX_MODE, cplx[dfir_pkg::CFG_BITS-1:0]);
      settings_used++;
      req_quiet = ($urandom_range(0, 3) == 0);
      rsp_quiet = ($urandom_range(0, 3) == 0);
      loaded = (taps == 0) ? 1 : (taps > dfir_pkg::MAX_TAPS) ? dfir_pkg::MAX_TAPS : taps;
      if ($urandom_range(0, 3) != 0)
         for (int j = 0; j < loaded; j++)
            send_request(as_row(random_request(dfir_pkg::CMD_TAP_WRITE, j)));
      n = $urandom_range(20, 60);
      repeat (n) begin
         if ($urandom_range(0, 15) == 0)
            send_request(as_row(random_request(dfir_pkg::CMD_TAP_WRITE, -1)));
         else
            send_request(as_row(random_request(dfir_pkg::CMD_SAMPLE, -1)));
      end
   endtask

   initial begin
      output_type got;
      output_type want;
      int         stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.re = rsp_tdata[dfir_pkg::OUT_BITS-1:0];
         got.im = rsp_tdata[2*dfir_pkg::OUT_BITS-1:dfir_pkg::OUT_BITS];
         if (pending_outputs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected output re %0d im %0d", $time, got.re, got.im);
         end else begin
            want = pending_outputs.pop_front();
            outputs_checked++;
            if (got.re !== want.re) begin
               mismatches++;
               $display("%0t: out_re expected %0d got %0d", $time, want.re, got.re);
            end
            if (got.im !== want.im) begin
               mismatches++;
               $display("%0t: out_im expected %0d got %0d", $time, want.im, got.im);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      int phase_no;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = dfir_pkg::CMD_SAMPLE;
      req_quiet  = 1'b0;
      rsp_quiet  = 1'b0;
      requests_sent     = 0;
      tap_writes        = 0;
      outputs_predicted = 0;
      outputs_checked   = 0;
      mismatches        = 0;
      settings_used     = 1;
      for (int j = 0; j < dfir_pkg::MAX_TAPS; j++) begin
         line_re[j] = '0;
         line_im[j] = '0;
         coef[j]    = '0;
      end
      phase_pos = 0;
      decim_reg = 1;
      ntaps_reg = 1;
      cplx_reg  = 1'b0;

      add_request(dfir_pkg::CMD_SAMPLE, 32767, -32768, 0, 0, 1'b1, 0, 0);
      add_request(dfir_pkg::CMD_TAP_WRITE, 0, 0, 0, -32768);
      add_request(dfir_pkg::CMD_SAMPLE, -32768, 32767, 63, 32767, 1'b1, 1073741824, 0);
      add_request(dfir_pkg::CMD_SAMPLE, 32767, 0, 0, 0, 1'b1, -1073709056, 0);
      add_request(dfir_pkg::CMD_TAP_WRITE, -1, -1, 63, 32767);
      add_csr(dfir_pkg::CSR_TAP_COUNT, dfir_pkg::MAX_TAPS);
      add_csr(dfir_pkg::CSR_COMPLEX_MODE, 1);
      add_request(dfir_pkg::CMD_SAMPLE, -32768, -32768, 0, 0, 1'b1, 1073741824, 1073741824);
      add_request(dfir_pkg::CMD_SAMPLE, 12345, -23456, 21, -1);
      add_csr(dfir_pkg::CSR_DECIMATION, 5);
      add_request(dfir_pkg::CMD_SAMPLE, -1, 32767, 42, 0);
      add_request(dfir_pkg::CMD_SAMPLE, 21845, -21846, 0, 0);
      add_request(dfir_pkg::CMD_SAMPLE, 1, -1, 0, 0);
      add_csr(dfir_pkg::CSR_DECIMATION, 2);
      add_request(dfir_pkg::CMD_SAMPLE, 32767, 32767, 0, 0);
      add_request(dfir_pkg::CMD_TAP_WRITE, 0, 0, 1, 32767);
      add_request(dfir_pkg::CMD_SAMPLE, -32768, 32767, 0, 0);
      add_request(dfir_pkg::CMD_SAMPLE, 256, -256, 0, 0);
      add_csr(dfir_pkg::CSR_DECIMATION, 0);
      add_csr(dfir_pkg::CSR_TAP_COUNT, 0);
      add_request(dfir_pkg::CMD_SAMPLE, -1, 1, 0, 0, 1'b1, 32768, -32768);
      add_csr(dfir_pkg::CSR_DECIMATION, 127);
      add_csr(dfir_pkg::CSR_TAP_COUNT, 127);
      add_request(dfir_pkg::CMD_SAMPLE, 32767, -32768, 0, 0);
      add_request(dfir_pkg::CMD_SAMPLE, -32768, 32767, 0, 0);
      add_csr(dfir_pkg::CSR_COMPLEX_MODE, 0);
      add_request(dfir_pkg::CMD_SAMPLE, 4660, 22136, 0, 0);
      add_csr(dfir_pkg::CSR_DECIMATION, 1);
      add_request(dfir_pkg::CMD_SAMPLE, -4660, -22136, 0, 0);
      add_request(dfir_pkg::CMD_TAP_WRITE, 0, 0, 32, -1);
      add_request(dfir_pkg::CMD_SAMPLE, 32767, 32767, 0, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_csr(plan[i].addr, plan[i].value);
            settings_used++;
         end else begin
            send_request(plan[i]);
         end
      end

      phase_no = 0;
      while (requests_sent < ITEM_TARGET || outputs_predicted < OUTPUT_TARGET) begin
         run_phase(phase_no);
         phase_no++;
      end

      settle();
      $display("%0d requests (%0d tap writes) sent across %0d register settings",
               requests_sent, tap_writes, settings_used);
      $display("%0d filter outputs checked, %0d mismatches", outputs_checked, mismatches);
      if (mismatches == 0)
         $display("tb_decimating_fir_filter passed");
      else
         $display("tb_decimating_fir_filter failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_decimating_fir_filter failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dfir_pkg.sv
rtl/dfir_ctrl.sv
rtl/dfir_dp.sv
rtl/decimating_fir_filter.sv
tb/tb_decimating_fir_filter.sv
